FILE: rtl/core/bsms_pkg.sv
package bsms_pkg;

  localparam int BANK_BYTES_DEF = 49152;

  localparam logic [1:0] OP_SNOOP = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_EPOCH = 2'd2;

  localparam logic [10:0] SW_TEXT    = 11'h001;
  localparam logic [10:0] SW_MIXED   = 11'h002;
  localparam logic [10:0] SW_PAGE2   = 11'h004;
  localparam logic [10:0] SW_HIRES   = 11'h008;
  localparam logic [10:0] SW_80STORE = 11'h010;
  localparam logic [10:0] SW_AUXREAD = 11'h020;
  localparam logic [10:0] SW_AUXWR   = 11'h040;
  localparam logic [10:0] SW_ALTZP   = 11'h080;
  localparam logic [10:0] SW_80COL   = 11'h100;
  localparam logic [10:0] SW_ALTCHAR = 11'h200;
  localparam logic [10:0] SW_DHIRES  = 11'h400;
  localparam logic [10:0] KNOWN_PLAIN = 11'h7F0;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 96;

  typedef struct packed {
    logic accept;
    logic clear_en;
    logic load_query;
  } cmd_t;

  typedef struct packed {
    logic op_query;
    logic epoch_change;
    logic clr_last;
  } sts_t;

endpackage

FILE: rtl/core/bsms_ctrl.sv
module bsms_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  bsms_pkg::sts_t sts,
  output bsms_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc;

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    cmd.accept     = acc;
    cmd.clear_en   = 1'b0;
    cmd.load_query = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          if (sts.op_query) begin
            state_nxt = ST_READ;
          end else begin
            out_valid_nxt = 1'b1;
            // a new epoch wipes the valid bits before the next beat
            if (sts.epoch_change) state_nxt = ST_CLEAR;
          end
        end
      end
      ST_READ: begin
        cmd.load_query = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_read_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> out_valid_r) else $error("query result not shown");
  a_read_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_IDLE) else $error("read state held");
  a_epoch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !sts.op_query && sts.epoch_change |=> state_r == ST_CLEAR)
    else $error("epoch change without clear");
`endif

endmodule

FILE: rtl/core/bsms_dp.sv
module bsms_dp #(
  parameter int BANK_BYTES = bsms_pkg::BANK_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [bsms_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [1:0]                        in_tuser,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic                              cfg_data,
  output logic [bsms_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  bsms_pkg::cmd_t                    cmd,
  output bsms_pkg::sts_t                    sts
);

  localparam int DEPTH = 2 * BANK_BYTES;
  localparam int AW    = $clog2(DEPTH);

  logic [15:0] a;
  logic [7:0]  bdata;
  logic        rd, rstl, qaux;
  logic [31:0] ep;

  assign a     = in_tdata[15:0];
  assign bdata = in_tdata[23:16];
  assign rd    = in_tdata[24];
  assign rstl  = in_tdata[25];
  assign qaux  = in_tdata[26];
  assign ep    = in_tdata[58:27];

  logic        enh_r;
  logic [10:0] flags_r, flags_nxt, known_r, known_nxt;
  logic        seen_r;
  logic [31:0] last_ep_r, resets_r, losses_r;
  logic        bv_r;
  logic [7:0]  val_r;
  logic [AW-1:0] clr_r;

  logic [8:0]  mem [DEPTH];
  logic [8:0]  rd_data_r;
  logic        range_r;

  logic [10:0] init_known, sw_bit, needed;
  logic        on, aux, in_bank, wr_ok, snoop_acc;
  logic        text_a, hires_a;
  logic [AW-1:0] wr_idx, q_idx;

  assign init_known = enh_r ? 11'h000 : bsms_pkg::KNOWN_PLAIN;
  assign in_bank    = {1'b0, a} < 17'(BANK_BYTES);
  assign snoop_acc  = cmd.accept && (in_tuser == bsms_pkg::OP_SNOOP);

  assign sts.op_query     = (in_tuser == bsms_pkg::OP_QUERY);
  assign sts.epoch_change = (in_tuser == bsms_pkg::OP_EPOCH) && (ep != last_ep_r);
  assign sts.clr_last     = (clr_r == AW'(DEPTH - 1));

  // soft switch decode
  always_comb begin
    sw_bit = 11'h000;
    on     = a[0];
    if (a >= 16'hC050 && a <= 16'hC057) begin
      unique case (a[2:1])
        2'd0: sw_bit = bsms_pkg::SW_TEXT;
        2'd1: sw_bit = bsms_pkg::SW_MIXED;
        2'd2: sw_bit = bsms_pkg::SW_PAGE2;
        2'd3: sw_bit = bsms_pkg::SW_HIRES;
        default: sw_bit = 11'h000;
      endcase
    end else if (enh_r && !rd && a >= 16'hC000 && a <= 16'hC00F) begin
      unique case (a[3:1])
        3'd0: sw_bit = bsms_pkg::SW_80STORE;
        3'd1: sw_bit = bsms_pkg::SW_AUXREAD;
        3'd2: sw_bit = bsms_pkg::SW_AUXWR;
        3'd4: sw_bit = bsms_pkg::SW_ALTZP;
        3'd6: sw_bit = bsms_pkg::SW_80COL;
        3'd7: sw_bit = bsms_pkg::SW_ALTCHAR;
        default: sw_bit = 11'h000;
      endcase
    end else if (enh_r && (a == 16'hC05E || a == 16'hC05F)) begin
      sw_bit = bsms_pkg::SW_DHIRES;
      on     = !a[0];
    end
  end

  // bank select for ram writes
  always_comb begin
    text_a  = a >= 16'h0400 && a < 16'h0800;
    hires_a = a >= 16'h2000 && a < 16'h4000;
    if (a < 16'h0200) begin
      needed = bsms_pkg::SW_ALTZP;
      aux    = |(flags_r & bsms_pkg::SW_ALTZP);
    end else begin
      needed = bsms_pkg::SW_AUXWR;
      aux    = |(flags_r & bsms_pkg::SW_AUXWR);
      if (text_a || hires_a) begin
        needed = needed | bsms_pkg::SW_80STORE;
        if (|(flags_r & bsms_pkg::SW_80STORE)) begin
          if (hires_a) needed = needed | bsms_pkg::SW_HIRES;
          if (text_a || |(flags_r & bsms_pkg::SW_HIRES)) begin
            needed = (needed & ~bsms_pkg::SW_AUXWR) | bsms_pkg::SW_PAGE2;
            aux    = |(flags_r & bsms_pkg::SW_PAGE2);
          end
        end
      end
    end
    if (!enh_r) aux = 1'b0;
  end

  assign wr_ok  = snoop_acc && !rstl && a < 16'hC000 && !rd && in_bank &&
                  (!enh_r || ((known_r & needed) == needed));
  assign wr_idx = aux ? AW'(BANK_BYTES) + AW'(a) : AW'(a);
  assign q_idx  = qaux ? AW'(BANK_BYTES) + AW'(a) : AW'(a);

  always_comb begin
    flags_nxt = flags_r;
    known_nxt = known_r;
    if (snoop_acc) begin
      if (rstl && !seen_r) known_nxt = init_known;
      if (!rstl && a >= 16'hC000 && sw_bit != 11'h000) begin
        flags_nxt = (flags_r & ~sw_bit) | (on ? sw_bit : 11'h000);
        known_nxt = known_r | sw_bit;
      end
    end else if (cmd.accept && sts.epoch_change) begin
      known_nxt = init_known;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enh_r     <= 1'b0;
      flags_r   <= bsms_pkg::SW_TEXT;
      known_r   <= bsms_pkg::KNOWN_PLAIN;
      seen_r    <= 1'b0;
      last_ep_r <= 32'd0;
      resets_r  <= 32'd0;
      losses_r  <= 32'd0;
      bv_r      <= 1'b0;
      val_r     <= 8'd0;
      clr_r     <= '0;
    end else begin
      clr_r <= cmd.clear_en ? clr_r + AW'(1) : '0;
      if (cfg_valid && cfg_ready) begin
        enh_r   <= cfg_data;
        known_r <= cfg_data ? 11'h000 : bsms_pkg::KNOWN_PLAIN;
      end else begin
        known_r <= known_nxt;
      end
      flags_r <= flags_nxt;
      if (snoop_acc) begin
        seen_r <= rstl;
        if (rstl && !seen_r) resets_r <= resets_r + 32'd1;
      end
      if (cmd.accept && sts.epoch_change) begin
        last_ep_r <= ep;
        losses_r  <= losses_r + 32'd1;
      end
      if (cmd.accept) begin
        bv_r  <= 1'b0;
        val_r <= 8'd0;
      end else if (cmd.load_query) begin
        bv_r  <= range_r && rd_data_r[8];
        val_r <= (range_r && rd_data_r[8]) ? rd_data_r[7:0] : 8'd0;
      end
    end
  end

  // one write port shared by the clearing pass and snooped writes
  always_ff @(posedge clk) begin
    if (cmd.clear_en) mem[clr_r] <= 9'd0;
    else if (wr_ok)   mem[wr_idx] <= {1'b1, bdata};
    rd_data_r <= mem[q_idx];
    range_r   <= in_bank;
  end

  assign out_tdata = {1'b0, losses_r, resets_r, known_r, flags_r, val_r, bv_r};

endmodule

FILE: rtl/core/bus_snoop_memory_shadow_core.sv
// bus snoop memory shadow
// in channel: one beat per snooped bus cycle, shadow query or epoch notice;
//   the op code rides on in_tuser. out channel: one status beat per input
//   beat, in order. cfg channel: one write of the enhanced model bit, always
//   ready; the sender writes it only while no beat is in flight.
// result timing: a snoop or epoch beat gives its result beat the next cycle;
//   a query passes through the read state and the registered read of the
//   shadow memory before its result beat. throughput: one beat per cycle
//   for snoop beats and epoch beats with no change, as long as the output
//   is taken; no new beat is taken while a query is in its read state.
// an epoch change starts a clearing pass over all 2*BANK_BYTES entries of
//   the shadow memory (98304 at the default), one entry a cycle; no input
//   beat is taken meanwhile. the same pass runs right after reset.
// reset (rst_n low, synchronous) restores the switch flags, known mask and
//   counters. if the receiver stalls the output beat holds and no new input
//   beat is accepted until it is taken.
module bus_snoop_memory_shadow_core #(
  parameter int BANK_BYTES = bsms_pkg::BANK_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // address[15:0] bus_data[23:16] is_read[24] reset_line[25]
  // query_aux[26] epoch_value[58:27]
  input  logic [bsms_pkg::IN_DATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // byte_valid[0] byte_value[8:1] switch_flags[19:9] switch_known[30:20]
  // reset_count[62:31] loss_count[94:63]
  output logic [bsms_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data
);

  bsms_pkg::cmd_t cmd;
  bsms_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bsms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsms_dp #(.BANK_BYTES(BANK_BYTES)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .out_tdata(out_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

FILE: tb/sv/bus_snoop_memory_shadow_checker.sv
module bus_snoop_memory_shadow_checker #(
  parameter int BANK = bsms_pkg::BANK_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bsms_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bsms_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic                            cfg_data,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // first member lands in the top bits
  typedef struct packed {
    logic [31:0] losses;
    logic [31:0] resets;
    logic [10:0] known;
    logic [10:0] flags;
    logic [7:0]  byte_value;
    logic        byte_valid;
  } status_t;

  logic        enhanced;
  logic [10:0] flags_q;
  logic [10:0] known_q;
  logic        reset_level;
  logic [31:0] epoch_q;
  logic [31:0] resets_q;
  logic [31:0] losses_q;
  logic [7:0]  shadow_mem [0:1][0:BANK-1];
  bit          written    [0:1][0:BANK-1];
  status_t     status_q [$];

  function automatic logic [10:0] known_after_reset(input logic enh);
    return enh ? 11'h000 : bsms_pkg::KNOWN_PLAIN;
  endfunction

  task automatic clear_written();
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < BANK; i++) written[b][i] = 1'b0;
  endtask

  task automatic apply_snoop(input logic [15:0] a, input logic [7:0] data,
                             input logic rd, input logic rst);
    logic [10:0] sw;
    logic [10:0] needed;
    logic        on;
    logic        aux;
    logic        text_rgn;
    logic        hires_rgn;
    sw = '0;
    needed = '0;
    aux = 1'b0;
    if (rst && !reset_level) begin
      resets_q++;
      known_q = known_after_reset(enhanced);
    end
    reset_level = rst;
    if (rst) return;
    if (a >= 16'hC000) begin
      on = a[0];
      if (a >= 16'hC050 && a <= 16'hC057) begin
        case (a[2:1])
          2'd0: sw = bsms_pkg::SW_TEXT;
          2'd1: sw = bsms_pkg::SW_MIXED;
          2'd2: sw = bsms_pkg::SW_PAGE2;
          default: sw = bsms_pkg::SW_HIRES;
        endcase
      end else if (enhanced && !rd && a <= 16'hC00F) begin
        case (a[3:1])
          3'd0: sw = bsms_pkg::SW_80STORE;
          3'd1: sw = bsms_pkg::SW_AUXREAD;
          3'd2: sw = bsms_pkg::SW_AUXWR;
          3'd4: sw = bsms_pkg::SW_ALTZP;
          3'd6: sw = bsms_pkg::SW_80COL;
          3'd7: sw = bsms_pkg::SW_ALTCHAR;
          default: sw = '0;
        endcase
      end else if (enhanced && (a == 16'hC05E || a == 16'hC05F)) begin
        sw = bsms_pkg::SW_DHIRES;
        on = !a[0];
      end
      if (sw != 0) begin
        flags_q = (flags_q & ~sw) | (on ? sw : 11'h000);
        known_q |= sw;
      end
      return;
    end
    if (rd) return;
    if (enhanced) begin
      if (a < 16'h0200) begin
        needed = bsms_pkg::SW_ALTZP;
        aux = (flags_q & bsms_pkg::SW_ALTZP) != 0;
      end else begin
        text_rgn = a >= 16'h0400 && a < 16'h0800;
        hires_rgn = a >= 16'h2000 && a < 16'h4000;
        needed = bsms_pkg::SW_AUXWR;
        aux = (flags_q & bsms_pkg::SW_AUXWR) != 0;
        if (text_rgn || hires_rgn) begin
          needed |= bsms_pkg::SW_80STORE;
          if ((flags_q & bsms_pkg::SW_80STORE) != 0) begin
            if (hires_rgn) needed |= bsms_pkg::SW_HIRES;
            if (text_rgn || (flags_q & bsms_pkg::SW_HIRES) != 0) begin
              needed &= ~bsms_pkg::SW_AUXWR;
              needed |= bsms_pkg::SW_PAGE2;
              aux = (flags_q & bsms_pkg::SW_PAGE2) != 0;
            end
          end
        end
      end
      if ((known_q & needed) != needed) return;
    end
    if (a >= BANK) return;
    shadow_mem[aux][a] = data;
    written[aux][a] = 1'b1;
  endtask

  task automatic predict_status(input logic [1:0] op,
                                input logic [bsms_pkg::IN_DATA_W-1:0] d);
    status_t st;
    logic [15:0] a;
    logic [31:0] ep;
    st = '0;
    a = d[15:0];
    ep = d[58:27];
    if (op == bsms_pkg::OP_SNOOP) begin
      apply_snoop(a, d[23:16], d[24], d[25]);
    end else if (op == bsms_pkg::OP_QUERY) begin
      if (a < BANK && written[d[26]][a]) begin
        st.byte_valid = 1'b1;
        st.byte_value = shadow_mem[d[26]][a];
      end
    end else if (op == bsms_pkg::OP_EPOCH) begin
      if (ep != epoch_q) begin
        epoch_q = ep;
        clear_written();
        known_q = known_after_reset(enhanced);
        losses_q++;
      end
    end
    st.flags = flags_q;
    st.known = known_q;
    st.resets = resets_q;
    st.losses = losses_q;
    status_q.push_back(st);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    status_t got;
    if (!rst_n) begin
      enhanced = 1'b0;
      flags_q = bsms_pkg::SW_TEXT;
      known_q = known_after_reset(1'b0);
      reset_level = 1'b0;
      epoch_q = '0;
      resets_q = '0;
      losses_q = '0;
      if (fail_count == 0 && status_q.size() == 0) clear_written();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[94:0];
        if (status_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual %0h", $time, got);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          check_field("byte_valid", want.byte_valid, got.byte_valid);
          check_field("byte_value", want.byte_value, got.byte_value);
          check_field("switch_flags", want.flags, got.flags);
          check_field("switch_known", want.known, got.known);
          check_field("reset_count", want.resets, got.resets);
          check_field("loss_count", want.losses, got.losses);
        end
      end
      if (cfg_valid && cfg_ready) begin
        enhanced = cfg_data;
        known_q = known_after_reset(cfg_data);
      end
      if (in_tvalid && in_tready) predict_status(in_tuser, in_tdata);
    end
    pending <= status_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

FILE: tb/sv/bus_snoop_memory_shadow_core_tb.sv
module bus_snoop_memory_shadow_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 440;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [bsms_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]                      in_tuser = bsms_pkg::OP_SNOOP;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [bsms_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_data = 1'b0;
  int                              fail_count;
  int                              pending;
  logic                            no_idle = 1'b0;
  int                              ready_left = 0;
  int                              idle_cycles = 0;
  logic [31:0]                     epoch_sent = '0;
  int                              epoch_changes = 0;

  always #5 clk = ~clk;

  bus_snoop_memory_shadow_core u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_valid, .cfg_ready, .cfg_data
  );

  bus_snoop_memory_shadow_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_valid, .cfg_ready, .cfg_data,
    .fail_count, .pending
  );

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (no_idle) begin
      out_tready <= 1'b1;
    end else if (ready_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        ready_left <= $urandom_range(1, 14);
      end else begin
        out_tready <= 1'b1;
        ready_left <= $urandom_range(1, 30);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [bsms_pkg::IN_DATA_W-1:0] pack_beat(
    input logic [15:0] a, input logic [7:0] data, input logic rd, input logic rst,
    input logic qaux, input logic [31:0] ep);
    return {5'd0, ep, qaux, rst, rd, data, a};
  endfunction

  task automatic send_beat(input logic [1:0] op,
                           input logic [bsms_pkg::IN_DATA_W-1:0] d);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic snoop(input logic [15:0] a, input logic [7:0] data, input logic rd,
                       input logic rst = 1'b0);
    send_beat(bsms_pkg::OP_SNOOP, pack_beat(a, data, rd, rst, 1'b0, epoch_sent));
  endtask

  task automatic query(input logic [15:0] a, input logic qaux);
    send_beat(bsms_pkg::OP_QUERY, pack_beat(a, 8'($urandom), 1'($urandom), 1'($urandom),
                                            qaux, epoch_sent));
  endtask

  task automatic epoch(input logic [31:0] ep);
    if (ep != epoch_sent) epoch_changes++;
    epoch_sent = ep;
    send_beat(bsms_pkg::OP_EPOCH, pack_beat(16'($urandom), 8'($urandom), 1'($urandom),
                                            1'($urandom), 1'($urandom), ep));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic enh);
    cfg_valid <= 1'b1;
    cfg_data <= enh;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // addresses cluster around region borders so queries hit written bytes
  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 7))
      0: return 16'h0000 + 16'($urandom_range(0, 15));
      1: return 16'h01F8 + 16'($urandom_range(0, 15));
      2: return 16'h03F8 + 16'($urandom_range(0, 15));
      3: return 16'h07F8 + 16'($urandom_range(0, 15));
      4: return 16'h1FF8 + 16'($urandom_range(0, 15));
      5: return 16'h3FF8 + 16'($urandom_range(0, 15));
      6: return 16'hBFF0 + 16'($urandom_range(0, 31));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_beat();
    int sel;
    logic [15:0] a;
    sel = $urandom_range(0, 99);
    if (sel < 22) begin
      a = $urandom_range(0, 1) ? 16'hC000 + 16'($urandom_range(0, 15))
                               : 16'hC050 + 16'($urandom_range(0, 15));
      snoop(a, 8'($urandom), $urandom_range(0, 3) == 0);
    end else if (sel < 52) begin
      snoop(pick_addr(), 8'($urandom), $urandom_range(0, 7) == 0,
            $urandom_range(0, 59) == 0);
    end else if (sel < 90) begin
      query(pick_addr(), 1'($urandom));
    end else if (sel < 96) begin
      if (epoch_changes < 5 && $urandom_range(0, 79) == 0) epoch($urandom);
      else epoch(epoch_sent);
    end else begin
      send_beat(OP_UNUSED, {5'd0, 32'($urandom), 27'($urandom)});
    end
  endtask

  initial begin
    logic mode_seq [4];
    mode_seq = '{1'b0, 1'b1, 1'b0, 1'b1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // plain model
    write_mode(1'b0);
    snoop(16'h0000, 8'hFF, 1'b0);
    query(16'h0000, 1'b0);
    query(16'h0000, 1'b1);
    snoop(16'hBFFF, 8'h00, 1'b0);
    query(16'hBFFF, 1'b0);
    query(16'hFFFF, 1'b0);
    snoop(16'hC057, 8'h5A, 1'b1);
    snoop(16'hC052, 8'hA5, 1'b0);
    snoop(16'hC05E, 8'h00, 1'b0);
    snoop(16'h1234, 8'h77, 1'b1);
    snoop(16'h0010, 8'h00, 1'b0, 1'b1);
    snoop(16'h0010, 8'h00, 1'b0, 1'b1);
    snoop(16'h0010, 8'h33, 1'b0);
    epoch(32'h0000_0000);
    epoch(32'hFFFF_FFFF);
    send_beat(OP_UNUSED, '1);
    drain();

    // enhanced model banking
    write_mode(1'b1);
    snoop(16'h0100, 8'h11, 1'b0);
    snoop(16'hC009, 8'h00, 1'b0);
    snoop(16'h0100, 8'h22, 1'b0);
    snoop(16'hC001, 8'h00, 1'b0);
    snoop(16'hC005, 8'h00, 1'b0);
    snoop(16'hC006, 8'h00, 1'b0);
    snoop(16'hC05E, 8'h00, 1'b1);
    snoop(16'h0400, 8'h44, 1'b0);
    snoop(16'hC055, 8'h00, 1'b1);
    snoop(16'h0400, 8'h55, 1'b0);
    snoop(16'hC057, 8'h00, 1'b1);
    snoop(16'h2000, 8'h66, 1'b0);
    query(16'h0100, 1'b1);
    query(16'h0400, 1'b1);
    query(16'h2000, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_mode(mode_seq[p]);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (p == 3 && i == PHASE_BEATS / 2) no_idle = 1'b1;
        random_beat();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
